### hw/rtl/cpep_pkg.sv
// Package for the constant-pool entry parser: tag, kind and float-class codes,
// the result bundle and the small decode functions. Depends on nothing.
`default_nettype none
package cpep_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] index_t;
  typedef logic [63:0] value_t;
  typedef logic [3:0]  pos_t;

  localparam pos_t POS_TAG     = 4'd0;
  localparam pos_t POS_CONTENT = 4'd15;

  localparam byte_t TAG_UTF8           = 8'd1;
  localparam byte_t TAG_INTEGER        = 8'd3;
  localparam byte_t TAG_FLOAT          = 8'd4;
  localparam byte_t TAG_LONG           = 8'd5;
  localparam byte_t TAG_DOUBLE         = 8'd6;
  localparam byte_t TAG_CLASS          = 8'd7;
  localparam byte_t TAG_STRING         = 8'd8;
  localparam byte_t TAG_FIELDREF       = 8'd9;
  localparam byte_t TAG_METHODREF      = 8'd10;
  localparam byte_t TAG_IMETHODREF     = 8'd11;
  localparam byte_t TAG_NAME_AND_TYPE  = 8'd12;
  localparam byte_t TAG_METHOD_HANDLE  = 8'd15;
  localparam byte_t TAG_METHOD_TYPE    = 8'd16;
  localparam byte_t TAG_INVOKE_DYNAMIC = 8'd18;

  localparam logic [1:0] KIND_FIXED     = 2'd0;
  localparam logic [1:0] KIND_UTF8_HDR  = 2'd1;
  localparam logic [1:0] KIND_UTF8_BYTE = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  localparam logic [1:0] FC_FINITE  = 2'd0;
  localparam logic [1:0] FC_POS_INF = 2'd1;
  localparam logic [1:0] FC_NEG_INF = 2'd2;
  localparam logic [1:0] FC_NAN     = 2'd3;

  localparam logic [31:0] F32_EXP_MASK  = 32'h7f80_0000;
  localparam logic [31:0] F32_NEG_INF   = 32'hff80_0000;
  localparam logic [31:0] F32_MANT_MASK = 32'h007f_ffff;
  localparam logic [63:0] F64_EXP_MASK  = 64'h7ff0_0000_0000_0000;
  localparam logic [63:0] F64_NEG_INF   = 64'hfff0_0000_0000_0000;
  localparam logic [63:0] F64_MANT_MASK = 64'h000f_ffff_ffff_ffff;

  typedef struct packed {
    logic [1:0] entry_kind;
    byte_t      entry_tag;
    index_t     first_index;
    index_t     second_index;
    value_t     value_bits;
    logic [1:0] float_class;
    logic       last_of_entry;
  } result_t;

  // Body length in bytes; zero marks an invalid tag.
  function automatic pos_t body_len(input byte_t tag);
    pos_t len;
    case (tag)
      TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: len = 4'd2;
      TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF,
      TAG_NAME_AND_TYPE, TAG_INVOKE_DYNAMIC: len = 4'd4;
      TAG_LONG, TAG_DOUBLE: len = 4'd8;
      TAG_METHOD_HANDLE: len = 4'd3;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [1:0] class32(input logic [31:0] x);
    logic [1:0] fc;
    if ((x & F32_EXP_MASK) != F32_EXP_MASK) fc = FC_FINITE;
    else if ((x & F32_MANT_MASK) != 32'd0) fc = FC_NAN;
    else if (x == F32_EXP_MASK) fc = FC_POS_INF;
    else fc = FC_NEG_INF;
    return fc;
  endfunction

  function automatic logic [1:0] class64(input logic [63:0] x);
    logic [1:0] fc;
    if ((x & F64_EXP_MASK) != F64_EXP_MASK) fc = FC_FINITE;
    else if ((x & F64_MANT_MASK) != 64'd0) fc = FC_NAN;
    else if (x == F64_EXP_MASK) fc = FC_POS_INF;
    else fc = FC_NEG_INF;
    return fc;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/class_constant_pool_entry_parser_top.sv
// The beat completed by an accepted byte is registered into the output register,
// or into the skid while that register is held. Throughput: one byte per cycle while
// in_stall is low; a two-deep output (register plus skid) absorbs a stall.
// Reset (rst, synchronous): expect a tag, clear the error halt, empty the output.
// Uses cpep_pkg for codes, the result bundle and the tag/float decode functions.
`default_nettype none
module class_constant_pool_entry_parser_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output      logic           in_stall,
  input  wire cpep_pkg::byte_t data_byte,
  input  wire logic           restart,
  output      logic           out_valid,
  input  wire logic           out_stall,
  output      logic [1:0]     entry_kind,
  output      cpep_pkg::byte_t entry_tag,
  output      cpep_pkg::index_t first_index,
  output      cpep_pkg::index_t second_index,
  output      cpep_pkg::value_t value_bits,
  output      logic [1:0]     float_class,
  output      logic           last_of_entry
);
  import cpep_pkg::*;

  // Parser state.
  pos_t    byte_position, byte_position_next;
  byte_t   current_tag, current_tag_next;
  value_t  field_shift, field_shift_next;
  index_t  utf8_remaining, utf8_remaining_next;
  logic    halted_on_error, halted_on_error_next;

  // Output register and skid stage.
  result_t out_res, skid_res, res;
  logic    skid_valid, res_valid;

  logic    in_accept, out_take;
  pos_t    pos_eff;
  value_t  shifted;
  index_t  utf8_dec;

  // The skid stage only fills while the output register is held, so stall
  // the input exactly while it is occupied.
  assign in_stall  = skid_valid;
  assign in_accept = in_valid & ~skid_valid;
  assign out_take  = out_valid & ~out_stall;

  // Restart forces the byte to be read as a tag.
  assign pos_eff  = restart ? POS_TAG : byte_position;
  assign shifted  = {field_shift[55:0], data_byte};
  assign utf8_dec = utf8_remaining - 16'd1;

  always_comb begin
    byte_position_next   = byte_position;
    current_tag_next     = current_tag;
    field_shift_next     = field_shift;
    utf8_remaining_next  = utf8_remaining;
    halted_on_error_next = halted_on_error;
    res                  = '0;
    res_valid            = 1'b0;

    if (in_accept) begin
      byte_position_next   = pos_eff;
      halted_on_error_next = halted_on_error & ~restart;
      if (!(halted_on_error & ~restart)) begin
        if (pos_eff == POS_TAG) begin
          if (body_len(data_byte) == 4'd0) begin
            // Unknown tag: report the byte and halt until restart.
            halted_on_error_next = 1'b1;
            res.entry_kind       = KIND_ERROR;
            res.entry_tag        = data_byte;
            res.last_of_entry    = 1'b1;
            res_valid            = 1'b1;
          end else begin
            current_tag_next    = data_byte;
            field_shift_next    = '0;
            utf8_remaining_next = '0;
            byte_position_next  = 4'd1;
          end
        end else if (pos_eff == POS_CONTENT) begin
          utf8_remaining_next = utf8_dec;
          if (utf8_dec == 16'd0) byte_position_next = POS_TAG;
          res.entry_kind    = KIND_UTF8_BYTE;
          res.entry_tag     = TAG_UTF8;
          res.value_bits    = {56'd0, data_byte};
          res.last_of_entry = (utf8_dec == 16'd0);
          res_valid         = 1'b1;
        end else begin
          // Body byte: shift in big-endian, emit once the body is complete.
          field_shift_next   = shifted;
          byte_position_next = pos_eff + 4'd1;
          if (pos_eff >= body_len(current_tag)) begin
            byte_position_next = POS_TAG;
            res_valid          = 1'b1;
            res.entry_tag      = current_tag;
            res.last_of_entry  = 1'b1;
            res.entry_kind     = KIND_FIXED;
            case (current_tag)
              TAG_UTF8: begin
                utf8_remaining_next = shifted[15:0];
                if (shifted[15:0] != 16'd0) byte_position_next = POS_CONTENT;
                res.entry_kind    = KIND_UTF8_HDR;
                res.value_bits    = {48'd0, shifted[15:0]};
                res.last_of_entry = (shifted[15:0] == 16'd0);
              end
              TAG_INTEGER: res.value_bits = {32'd0, shifted[31:0]};
              TAG_FLOAT: begin
                res.value_bits  = {32'd0, shifted[31:0]};
                res.float_class = class32(shifted[31:0]);
              end
              TAG_LONG: res.value_bits = shifted;
              TAG_DOUBLE: begin
                res.value_bits  = shifted;
                res.float_class = class64(shifted);
              end
              TAG_METHOD_HANDLE: begin
                res.first_index  = {8'd0, shifted[23:16]};
                res.second_index = shifted[15:0];
              end
              TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: res.first_index = shifted[15:0];
              default: begin
                // Two-index entries.
                res.first_index  = shifted[31:16];
                res.second_index = shifted[15:0];
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= POS_TAG;
      current_tag     <= '0;
      field_shift     <= '0;
      utf8_remaining  <= '0;
      halted_on_error <= 1'b0;
    end else begin
      byte_position   <= byte_position_next;
      current_tag     <= current_tag_next;
      field_shift     <= field_shift_next;
      utf8_remaining  <= utf8_remaining_next;
      halted_on_error <= halted_on_error_next;
    end
  end

  // Output register with skid: refill from the skid first, else from the
  // new beat; while the output is held, park a new beat in the skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      out_valid  <= skid_valid | res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

  assign entry_kind    = out_res.entry_kind;
  assign entry_tag     = out_res.entry_tag;
  assign first_index   = out_res.first_index;
  assign second_index  = out_res.second_index;
  assign value_bits    = out_res.value_bits;
  assign float_class   = out_res.float_class;
  assign last_of_entry = out_res.last_of_entry;

endmodule
`default_nettype wire

### hw/rtl/cpep_checker.sv
// Port-level checker for the constant-pool entry parser, bound to the top level.
// Uses cpep_pkg for kind and tag codes.
`default_nettype none
module cpep_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire logic [1:0]     entry_kind,
  input wire cpep_pkg::byte_t entry_tag,
  input wire cpep_pkg::index_t first_index,
  input wire logic [1:0]     float_class,
  input wire logic           last_of_entry
);
  import cpep_pkg::*;

  // Input stalls only while a beat is backed up behind a held output.
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid) else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("held output beat dropped");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_kind == KIND_ERROR |-> last_of_entry)
    else $error("error beat without last mark");

  a_content_tag: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_kind == KIND_UTF8_BYTE |-> entry_tag == TAG_UTF8 && first_index == 16'd0)
    else $error("utf8 content beat with wrong tag or index");

  a_float_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && float_class != FC_FINITE |->
      entry_kind == KIND_FIXED && (entry_tag == TAG_FLOAT || entry_tag == TAG_DOUBLE))
    else $error("float class on a non-float entry");

endmodule

bind class_constant_pool_entry_parser_top cpep_checker u_cpep_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .entry_kind(entry_kind), .entry_tag(entry_tag),
  .first_index(first_index), .float_class(float_class),
  .last_of_entry(last_of_entry)
);
`default_nettype wire
